// ----- design/rvdec_pkg.sv -----
package rvdec_pkg;

  // major opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_WORD = 3'd2;

  // instruction codes
  localparam logic [3:0] CODE_ADD   = 4'd0;
  localparam logic [3:0] CODE_SUB   = 4'd1;
  localparam logic [3:0] CODE_ADDI  = 4'd2;
  localparam logic [3:0] CODE_LW    = 4'd3;
  localparam logic [3:0] CODE_SW    = 4'd4;
  localparam logic [3:0] CODE_BEQ   = 4'd5;
  localparam logic [3:0] CODE_LUI   = 4'd6;
  localparam logic [3:0] CODE_AUIPC = 4'd7;
  localparam logic [3:0] CODE_JAL   = 4'd8;
  localparam logic [3:0] CODE_JALR  = 4'd9;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] pc_value;
  } rvdec_in_t;

  typedef struct packed {
    logic [3:0]         instr_code;
    logic               illegal;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        target_addr;
  } rvdec_out_t;

endpackage

// ----- design/rv32i_subset_instruction_decoder_top.sv -----
// Decoder for a subset of the RV32I base set (ADD, SUB, ADDI, LW, SW, BEQ, LUI,
// AUIPC, JAL, JALR). Each input transaction carries an instruction word and its
// pc; each produces exactly one output transaction with the instruction code,
// the raw rd/rs1/rs2 fields, the sign-extended immediate of the format and, for
// BEQ and JAL, the pc-relative target (wraps modulo 2^32). Unsupported
// encodings set illegal and force code, immediate and target to zero, while the
// register fields still carry the raw bits. The block is a two-register
// pipeline: an input register, then the decode and one 32-bit target adder,
// then the output register; a transaction passes both before out_valid.
// Throughput, set by the single decode pass, is one transaction per cycle
// while out_ready is high. Each register advances when its downstream side
// is free; an empty input register still takes input while a result waits.
module rv32i_subset_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rvdec_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rvdec_out_t out_data
);

  // input register
  logic      in_valid_r;
  rvdec_in_t in_data_r;
  // output register
  logic       out_valid_r;
  rvdec_out_t out_data_r;
  rvdec_out_t out_data_nxt;

  logic out_free;
  logic in_free;

  // a stage may load when it is empty or its content leaves this cycle
  assign out_free = !out_valid_r || out_ready;
  assign in_free  = !in_valid_r || out_free;
  assign in_ready = in_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_free) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // decode fields of the registered word
  logic [31:0] w;
  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [31:0] imm_sel;
  logic [3:0]  code_sel;
  logic        ok;
  logic        use_target;

  assign w      = in_data_r.instr_word;
  assign opcode = w[6:0];
  assign f3     = w[14:12];
  assign f7     = w[31:25];

  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_u = {w[31:12], 12'h000};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

  always_comb begin
    code_sel   = CODE_ADD;
    imm_sel    = '0;
    ok         = 1'b0;
    use_target = 1'b0;
    unique case (opcode)
      OP_REG: begin
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          code_sel = CODE_ADD;
          ok       = 1'b1;
        end else if (f3 == F3_ADD && f7 == F7_ALT) begin
          code_sel = CODE_SUB;
          ok       = 1'b1;
        end
      end
      OP_IMM: begin
        code_sel = CODE_ADDI;
        imm_sel  = imm_i;
        ok       = (f3 == F3_ADD);
      end
      OP_LOAD: begin
        code_sel = CODE_LW;
        imm_sel  = imm_i;
        ok       = (f3 == F3_WORD);
      end
      OP_STORE: begin
        code_sel = CODE_SW;
        imm_sel  = imm_s;
        ok       = (f3 == F3_WORD);
      end
      OP_BRANCH: begin
        code_sel   = CODE_BEQ;
        imm_sel    = imm_b;
        ok         = (f3 == F3_BEQ);
        use_target = 1'b1;
      end
      OP_LUI: begin
        code_sel = CODE_LUI;
        imm_sel  = imm_u;
        ok       = 1'b1;
      end
      OP_AUIPC: begin
        code_sel = CODE_AUIPC;
        imm_sel  = imm_u;
        ok       = 1'b1;
      end
      OP_JAL: begin
        code_sel   = CODE_JAL;
        imm_sel    = imm_j;
        ok         = 1'b1;
        use_target = 1'b1;
      end
      OP_JALR: begin
        code_sel = CODE_JALR;
        imm_sel  = imm_i;
        ok       = (f3 == F3_ADD);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // illegal encodings zero code, immediate and target; raw reg fields always pass
  always_comb begin
    out_data_nxt.instr_code  = ok ? code_sel : CODE_ADD;
    out_data_nxt.illegal     = !ok;
    out_data_nxt.dest_reg    = w[11:7];
    out_data_nxt.src1_reg    = w[19:15];
    out_data_nxt.src2_reg    = w[24:20];
    out_data_nxt.immediate   = ok ? imm_sel : '0;
    out_data_nxt.target_addr = (ok && use_target) ? (in_data_r.pc_value + imm_sel) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // illegal transactions carry zero code, immediate and target
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.illegal) |->
      (out_data_r.instr_code == CODE_ADD && out_data_r.immediate == '0 &&
       out_data_r.target_addr == '0))
    else $error("illegal transaction with nonzero code, immediate or target");

  // only BEQ and JAL produce a target
  a_target_only_branch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.instr_code != CODE_BEQ &&
     out_data_r.instr_code != CODE_JAL) |-> (out_data_r.target_addr == '0))
    else $error("target set for instruction that is not BEQ or JAL");

  // R-type results have no immediate
  a_rtype_no_imm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.instr_code == CODE_ADD ||
     out_data_r.instr_code == CODE_SUB)) |-> (out_data_r.immediate == '0))
    else $error("R-type transaction with nonzero immediate");

  // a full pipeline with a stalled output must not take a new transaction
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both registers are held");

  // a held input register moves to the output once the output frees up
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_free) |=> out_valid_r)
    else $error("registered transaction lost between stages");

endmodule
